### src/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and constants for the LED blink controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lbc_pkg;

   localparam int LED_COUNT = 3;
   localparam int TICK_MS   = 100;

   localparam int CMD_W   = 3;
   localparam int IDX_W   = 3;
   localparam int MS_W    = 16;
   localparam int PIN_W   = 3;
   localparam int TICK_W  = 10;
   localparam int WALK_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

   localparam logic [TICK_W-1:0] TICKS_MAX = TICK_W'(1023);

   // ms / TICK_MS as multiply by rounded-up reciprocal, exact for MS_W-bit inputs
   localparam int DIV_SHIFT = MS_W + $clog2(TICK_MS);
   localparam int RECIP_W   = MS_W + 1;
   localparam int PROD_W    = MS_W + RECIP_W;
   localparam int QUOT_W    = PROD_W - DIV_SHIFT;
   localparam logic [RECIP_W-1:0] DIV_RECIP =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS));

   typedef enum logic [CMD_W-1:0] {
      CMD_ON         = 3'd0,
      CMD_OFF        = 3'd1,
      CMD_TOGGLE     = 3'd2,
      CMD_BLINK      = 3'd3,
      CMD_TEST_START = 3'd4,
      CMD_TEST_END   = 3'd5,
      CMD_TICK       = 3'd6
   } cmd_code_type;

   typedef enum logic [1:0] {
      MODE_OFF   = 2'd0,
      MODE_ON    = 2'd1,
      MODE_BLINK = 2'd2
   } led_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_WORK   = 2'd1,
      ST_FINISH = 2'd2
   } state_type;

   typedef struct packed {
      logic              load_item;
      logic              step_en;
      logic              load_rsp;
      logic [WALK_W-1:0] walk_idx;
   } lbc_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic rsp_busy;
   } lbc_sts_type;

endpackage

`default_nettype wire

### src/lbc_ctrl.sv
// ----------------------------------------------------------------------------
// lbc_ctrl
// Sequencer: takes a word, walks the LEDs for a tick, then loads the result.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  lbc_pkg::lbc_sts_type sts,
   output lbc_pkg::lbc_cmd_type cmd
);

   lbc_pkg::state_type            state_ff, state_in;
   logic [lbc_pkg::WALK_W-1:0]    walk_ff, walk_in;
   logic                          last_led;

   assign last_led = (walk_ff == lbc_pkg::WALK_W'(lbc_pkg::LED_COUNT - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lbc_pkg::ST_IDLE;
         walk_ff  <= '0;
      end else begin
         state_ff <= state_in;
         walk_ff  <= walk_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      walk_in  = walk_ff;
      case (state_ff)
         lbc_pkg::ST_IDLE: begin
            walk_in = '0;
            if (req_valid) state_in = lbc_pkg::ST_WORK;
         end
         lbc_pkg::ST_WORK: begin
            if (!sts.is_tick || last_led) begin
               state_in = lbc_pkg::ST_FINISH;
               walk_in  = '0;
            end else begin
               walk_in = walk_ff + lbc_pkg::WALK_W'(1);
            end
         end
         lbc_pkg::ST_FINISH: begin
            if (!sts.rsp_busy) state_in = lbc_pkg::ST_IDLE;
         end
         default: begin
            state_in = lbc_pkg::ST_IDLE;
            walk_in  = '0;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = 1'b0;
      cmd.load_item = 1'b0;
      cmd.step_en   = 1'b0;
      cmd.load_rsp  = 1'b0;
      cmd.walk_idx  = walk_ff;
      case (state_ff)
         lbc_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         lbc_pkg::ST_WORK: begin
            cmd.step_en = 1'b1;
         end
         lbc_pkg::ST_FINISH: begin
            cmd.load_rsp = !sts.rsp_busy;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   a_accept_to_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == lbc_pkg::ST_WORK))
      else $error("accepted word did not start work");

   a_walk_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lbc_pkg::ST_IDLE) |-> (walk_ff == '0))
      else $error("walk counter not cleared in idle");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !sts.rsp_busy)
      else $error("result loaded over a pending word");

   a_finish_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lbc_pkg::ST_FINISH && !sts.rsp_busy) |=> (state_ff == lbc_pkg::ST_IDLE))
      else $error("finish did not return to idle");

endmodule

`default_nettype wire

### src/lbc_datapath.sv
// ----------------------------------------------------------------------------
// lbc_datapath
// Per-LED state, command update for one LED per cycle, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_datapath (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  [lbc_pkg::CMD_W-1:0]        req_cmd,
   input  wire  [lbc_pkg::IDX_W-1:0]        req_led_index,
   input  wire  [lbc_pkg::MS_W-1:0]         req_blink_period_ms,
   input  wire                              csr_wr_en,
   input  wire  [lbc_pkg::PIN_W-1:0]        csr_wr_data,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [lbc_pkg::PIN_W-1:0]        rsp_pin_levels,
   input  lbc_pkg::lbc_cmd_type             cmd,
   output lbc_pkg::lbc_sts_type             sts
);

   localparam int N = lbc_pkg::LED_COUNT;

   logic [lbc_pkg::CMD_W-1:0]  cmd_ff;
   logic [lbc_pkg::IDX_W-1:0]  idx_ff;
   logic [lbc_pkg::MS_W-1:0]   ms_ff;
   logic [lbc_pkg::PIN_W-1:0]  mask_ff;
   logic                       rsp_valid_ff;
   logic [lbc_pkg::PIN_W-1:0]  pins_ff;

   lbc_pkg::led_mode_type      mode_ff  [N];
   lbc_pkg::led_mode_type      mode_in  [N];
   lbc_pkg::led_mode_type      saved_ff [N];
   lbc_pkg::led_mode_type      saved_in [N];
   logic                       lit_ff   [N];
   logic                       lit_in   [N];
   logic [lbc_pkg::TICK_W-1:0] period_ff [N];
   logic [lbc_pkg::TICK_W-1:0] period_in [N];
   logic [lbc_pkg::TICK_W-1:0] count_ff  [N];
   logic [lbc_pkg::TICK_W-1:0] count_in  [N];

   logic                        is_tick;
   logic                        in_range;
   logic [lbc_pkg::WALK_W-1:0]  sel;
   logic [lbc_pkg::PROD_W-1:0]  prod;
   logic [lbc_pkg::QUOT_W-1:0]  quot;
   logic [lbc_pkg::TICK_W-1:0]  ticks;
   logic [lbc_pkg::TICK_W-1:0]  dec;
   logic [lbc_pkg::PIN_W-1:0]   pins_now;

   assign is_tick  = (cmd_ff == lbc_pkg::CMD_TICK);
   assign in_range = (idx_ff < lbc_pkg::IDX_W'(N));
   assign sel      = is_tick ? cmd.walk_idx : idx_ff[lbc_pkg::WALK_W-1:0];

   // period in ticks: divide, clamp to at least one tick, saturate
   assign prod = lbc_pkg::PROD_W'(ms_ff) * lbc_pkg::PROD_W'(lbc_pkg::DIV_RECIP);
   assign quot = prod[lbc_pkg::PROD_W-1:lbc_pkg::DIV_SHIFT];
   always_comb begin
      if (quot == '0)
         ticks = lbc_pkg::TICK_W'(1);
      else if (quot > lbc_pkg::QUOT_W'(lbc_pkg::TICKS_MAX))
         ticks = lbc_pkg::TICKS_MAX;
      else
         ticks = lbc_pkg::TICK_W'(quot);
   end

   assign dec = count_ff[sel] - lbc_pkg::TICK_W'(1);

   always_comb begin
      for (int i = 0; i < N; i++) begin
         mode_in[i]   = mode_ff[i];
         saved_in[i]  = saved_ff[i];
         lit_in[i]    = lit_ff[i];
         period_in[i] = period_ff[i];
         count_in[i]  = count_ff[i];
      end
      if (cmd.step_en) begin
         if (is_tick) begin
            if (mode_ff[sel] == lbc_pkg::MODE_BLINK) begin
               if (dec == '0) begin
                  count_in[sel] = period_ff[sel];
                  lit_in[sel]   = !lit_ff[sel];
               end else begin
                  count_in[sel] = dec;
               end
            end
         end else if (in_range) begin
            case (cmd_ff)
               lbc_pkg::CMD_ON: begin
                  mode_in[sel] = lbc_pkg::MODE_ON;
                  lit_in[sel]  = 1'b1;
               end
               lbc_pkg::CMD_OFF: begin
                  mode_in[sel] = lbc_pkg::MODE_OFF;
                  lit_in[sel]  = 1'b0;
               end
               lbc_pkg::CMD_TOGGLE: begin
                  if (mode_ff[sel] != lbc_pkg::MODE_BLINK) begin
                     mode_in[sel] = (mode_ff[sel] == lbc_pkg::MODE_ON) ?
                                    lbc_pkg::MODE_OFF : lbc_pkg::MODE_ON;
                     lit_in[sel]  = !lit_ff[sel];
                  end
               end
               lbc_pkg::CMD_BLINK: begin
                  mode_in[sel]   = lbc_pkg::MODE_BLINK;
                  period_in[sel] = ticks;
                  count_in[sel]  = ticks;
                  lit_in[sel]    = 1'b1;
               end
               lbc_pkg::CMD_TEST_START: begin
                  saved_in[sel] = mode_ff[sel];
                  if (mode_ff[sel] == lbc_pkg::MODE_ON || mode_ff[sel] == lbc_pkg::MODE_BLINK) begin
                     mode_in[sel] = lbc_pkg::MODE_OFF;
                     lit_in[sel]  = 1'b0;
                  end else begin
                     mode_in[sel] = lbc_pkg::MODE_ON;
                     lit_in[sel]  = 1'b1;
                  end
               end
               lbc_pkg::CMD_TEST_END: begin
                  mode_in[sel] = saved_ff[sel];
                  case (saved_ff[sel])
                     lbc_pkg::MODE_ON: begin
                        lit_in[sel] = 1'b1;
                     end
                     lbc_pkg::MODE_BLINK: begin
                        count_in[sel] = period_ff[sel];
                        lit_in[sel]   = 1'b1;
                     end
                     default: begin
                        lit_in[sel] = 1'b0;
                     end
                  endcase
               end
               default: begin
                  mode_in[sel] = mode_ff[sel];
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            mode_ff[i]   <= lbc_pkg::MODE_OFF;
            saved_ff[i]  <= lbc_pkg::MODE_OFF;
            lit_ff[i]    <= 1'b0;
            period_ff[i] <= '0;
            count_ff[i]  <= '0;
         end
         mask_ff      <= lbc_pkg::PIN_W'(6);
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < N; i++) begin
            mode_ff[i]   <= mode_in[i];
            saved_ff[i]  <= saved_in[i];
            lit_ff[i]    <= lit_in[i];
            period_ff[i] <= period_in[i];
            count_ff[i]  <= count_in[i];
         end
         if (csr_wr_en) mask_ff <= csr_wr_data;
         if (cmd.load_rsp)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         cmd_ff <= req_cmd;
         idx_ff <= req_led_index;
         ms_ff  <= req_blink_period_ms;
      end
      if (cmd.load_rsp) pins_ff <= pins_now;
   end

   for (genvar g = 0; g < lbc_pkg::PIN_W; g++) begin : g_pin
      if (g < N) begin : g_led
         assign pins_now[g] = lit_ff[g] ^ mask_ff[g];
      end else begin : g_none
         assign pins_now[g] = 1'b0;
      end
   end

   assign sts.is_tick  = is_tick;
   assign sts.rsp_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pin_levels = pins_ff;

endmodule

`default_nettype wire

### src/led_blink_controller_unit.sv
// ----------------------------------------------------------------------------
// led_blink_controller_unit
// LED bank controller: on/off/toggle/blink/test commands and blink ticks.
//
//   channel  direction  signals
//   req      in         req_valid, req_ready, req_cmd, req_led_index,
//                       req_blink_period_ms
//   rsp      out        rsp_valid, rsp_ready, rsp_pin_levels
//   csr      in         csr_wr_en, csr_wr_data (invert mask)
//
// rsp_valid rises as the controller goes from finish to idle, after the work
// step, which walks the LEDs one per cycle for a tick; req_ready returns with
// it, so no word is taken before the last result is loaded. Synchronous reset
// clears all LED state and sets the invert mask to 6. A stalled rsp holds the
// controller in its finish step until the pending word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module led_blink_controller_unit (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  [lbc_pkg::CMD_W-1:0]    req_cmd,
   input  wire  [lbc_pkg::IDX_W-1:0]    req_led_index,
   input  wire  [lbc_pkg::MS_W-1:0]     req_blink_period_ms,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [lbc_pkg::PIN_W-1:0]    rsp_pin_levels,
   input  wire                          csr_wr_en,
   input  wire  [lbc_pkg::PIN_W-1:0]    csr_wr_data
);

   lbc_pkg::lbc_cmd_type cmd;
   lbc_pkg::lbc_sts_type sts;

   lbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lbc_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_cmd             (req_cmd),
      .req_led_index       (req_led_index),
      .req_blink_period_ms (req_blink_period_ms),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pin_levels      (rsp_pin_levels),
      .cmd                 (cmd),
      .sts                 (sts)
   );

endmodule

`default_nettype wire
